[src/pdu_pkg.sv]
// ----------------------------------------------------------------------------
// pdu_pkg : shared types and codes for the planar primitive distance unit
// Kind codes, primitive shapes, the per-transaction control word and the
// decoder that picks the shape each distance lane works on.
// ----------------------------------------------------------------------------
`default_nettype none

package pdu_pkg;

   localparam int OUT_BITS  = 33;
   localparam int NUM_LANES = 4;

   localparam logic [3:0] KIND_PT_PT     = 4'd0;
   localparam logic [3:0] KIND_PT_SEG    = 4'd1;
   localparam logic [3:0] KIND_PT_RAY    = 4'd2;
   localparam logic [3:0] KIND_PT_LINE   = 4'd3;
   localparam logic [3:0] KIND_SEG_SEG   = 4'd4;
   localparam logic [3:0] KIND_SEG_RAY   = 4'd5;
   localparam logic [3:0] KIND_SEG_LINE  = 4'd6;
   localparam logic [3:0] KIND_RAY_RAY   = 4'd7;
   localparam logic [3:0] KIND_RAY_LINE  = 4'd8;
   localparam logic [3:0] KIND_LINE_LINE = 4'd9;

   typedef enum logic [1:0] {
      SHAPE_POINT = 2'd0,
      SHAPE_SEG   = 2'd1,
      SHAPE_RAY   = 2'd2,
      SHAPE_LINE  = 2'd3
   } shape_type;

   typedef struct packed {
      logic                 valid;
      logic                 zero;
      logic [NUM_LANES-1:0] lane_en;
   } pipe_ctl_type;

   // lane 0: p to (r,s), lane 1: q to (r,s), lane 2: r to (p,q), lane 3: s to (p,q)
   function automatic shape_type lane_shape(input logic [3:0] kind, input logic [1:0] lane);
      shape_type sh;
      sh = SHAPE_SEG;
      unique case (lane)
         2'd0: begin
            case (kind) inside
               KIND_PT_PT:                              sh = SHAPE_POINT;
               KIND_PT_SEG, KIND_SEG_SEG:               sh = SHAPE_SEG;
               KIND_PT_RAY, KIND_SEG_RAY, KIND_RAY_RAY: sh = SHAPE_RAY;
               default:                                 sh = SHAPE_LINE;
            endcase
         end
         2'd1: begin
            case (kind) inside
               KIND_SEG_RAY:  sh = SHAPE_RAY;
               KIND_SEG_LINE: sh = SHAPE_LINE;
               default:       sh = SHAPE_SEG;
            endcase
         end
         2'd2: begin
            case (kind) inside
               KIND_RAY_RAY, KIND_RAY_LINE: sh = SHAPE_RAY;
               KIND_LINE_LINE:              sh = SHAPE_LINE;
               default:                     sh = SHAPE_SEG;
            endcase
         end
         default: sh = SHAPE_SEG;
      endcase
      return sh;
   endfunction

endpackage

`default_nettype wire

[src/pdu_front.sv]
// ----------------------------------------------------------------------------
// pdu_front : crossing tests and lane enables
// Three register stages: differences, products, cross sums and decisions.
// ----------------------------------------------------------------------------
`default_nettype none

module pdu_front #(
   parameter int COORD_BITS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   input  logic [3:0]                    kind,
   input  logic signed [COORD_BITS-1:0]  p_x,
   input  logic signed [COORD_BITS-1:0]  p_y,
   input  logic signed [COORD_BITS-1:0]  q_x,
   input  logic signed [COORD_BITS-1:0]  q_y,
   input  logic signed [COORD_BITS-1:0]  r_x,
   input  logic signed [COORD_BITS-1:0]  r_y,
   input  logic signed [COORD_BITS-1:0]  s_x,
   input  logic signed [COORD_BITS-1:0]  s_y,
   output pdu_pkg::pipe_ctl_type         ctl
);
   import pdu_pkg::*;

   localparam int DIFW = COORD_BITS + 1;
   localparam int PRW  = 2 * DIFW;
   localparam int CRW  = PRW + 1;
   localparam int NRW  = CRW + 1;

   // stage 1: difference vectors
   logic                   valid1_ff, valid1_in;
   logic [3:0]             kind1_ff;
   logic signed [DIFW-1:0] v1x_ff, v1y_ff, v2x_ff, v2y_ff;
   logic signed [DIFW-1:0] prx_ff, pry_ff, qrx_ff, qry_ff;

   assign valid1_in = in_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid1_ff <= 1'b0;
      end else begin
         valid1_ff <= valid1_in;
      end
   end

   always_ff @(posedge clock) begin
      kind1_ff <= kind;
      v1x_ff   <= DIFW'(q_x) - DIFW'(p_x);
      v1y_ff   <= DIFW'(q_y) - DIFW'(p_y);
      v2x_ff   <= DIFW'(s_x) - DIFW'(r_x);
      v2y_ff   <= DIFW'(s_y) - DIFW'(r_y);
      prx_ff   <= DIFW'(p_x) - DIFW'(r_x);
      pry_ff   <= DIFW'(p_y) - DIFW'(r_y);
      qrx_ff   <= DIFW'(q_x) - DIFW'(r_x);
      qry_ff   <= DIFW'(q_y) - DIFW'(r_y);
   end

   // stage 2: products
   logic                  valid2_ff;
   logic [3:0]            kind2_ff;
   logic                  v1null_ff, v2null_ff;
   logic signed [PRW-1:0] m1a_ff, m1b_ff, maa_ff, mab_ff;
   logic signed [PRW-1:0] mba_ff, mbb_ff, mua_ff, mub_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid2_ff <= 1'b0;
      end else begin
         valid2_ff <= valid1_ff;
      end
   end

   always_ff @(posedge clock) begin
      kind2_ff  <= kind1_ff;
      v1null_ff <= (v1x_ff == '0) && (v1y_ff == '0);
      v2null_ff <= (v2x_ff == '0) && (v2y_ff == '0);
      m1a_ff    <= v1x_ff * v2y_ff;
      m1b_ff    <= v1y_ff * v2x_ff;
      maa_ff    <= v2x_ff * pry_ff;
      mab_ff    <= v2y_ff * prx_ff;
      mba_ff    <= v2x_ff * qry_ff;
      mbb_ff    <= v2y_ff * qrx_ff;
      mua_ff    <= v1x_ff * pry_ff;
      mub_ff    <= v1y_ff * prx_ff;
   end

   // stage 3: cross sums, crossing tests, lane enables
   logic signed [CRW-1:0] x1, xa, xb, xu;
   logic signed [NRW-1:0] dd_n, t_n, u_n;
   logic                  cross_tt, cross_tf, cross_rr;
   pipe_ctl_type          ctl_ff, ctl_in;

   assign x1 = CRW'(m1a_ff) - CRW'(m1b_ff);
   assign xa = CRW'(maa_ff) - CRW'(mab_ff);
   assign xb = CRW'(mba_ff) - CRW'(mbb_ff);
   assign xu = CRW'(mua_ff) - CRW'(mub_ff);

   // crossing parameters with the sign of the determinant folded in
   always_comb begin
      if (x1 < 0) begin
         dd_n = -NRW'(x1);
         t_n  = -NRW'(xa);
         u_n  = -NRW'(xu);
      end else begin
         dd_n = NRW'(x1);
         t_n  = NRW'(xa);
         u_n  = NRW'(xu);
      end
   end

   assign cross_rr = (x1 != '0) && (t_n >= 0) && (u_n >= 0);
   assign cross_tf = cross_rr && (t_n <= dd_n);
   assign cross_tt = cross_tf && (u_n <= dd_n);

   always_comb begin
      ctl_in.valid   = valid2_ff;
      ctl_in.zero    = 1'b0;
      ctl_in.lane_en = '0;
      case (kind2_ff) inside
         KIND_PT_PT, KIND_PT_SEG, KIND_PT_RAY, KIND_PT_LINE: begin
            ctl_in.lane_en = 4'b0001;
         end
         KIND_SEG_SEG: begin
            ctl_in.zero    = cross_tt;
            ctl_in.lane_en = 4'b1111;
         end
         KIND_SEG_RAY: begin
            ctl_in.zero    = cross_tf;
            ctl_in.lane_en = 4'b0111;
         end
         KIND_RAY_RAY: begin
            ctl_in.zero    = cross_rr;
            ctl_in.lane_en = 4'b0101;
         end
         KIND_SEG_LINE: begin
            ctl_in.zero    = !v2null_ff && (((xa <= 0) && (xb >= 0)) ||
                                            ((xa >= 0) && (xb <= 0)));
            ctl_in.lane_en = v2null_ff ? 4'b0100 : 4'b0011;
         end
         KIND_RAY_LINE: begin
            ctl_in.zero    = !v2null_ff && !v1null_ff &&
                             ((xa == '0) || ((xa > 0) && (x1 > 0)) ||
                              ((xa < 0) && (x1 < 0)));
            ctl_in.lane_en = v2null_ff ? 4'b0100 : 4'b0001;
         end
         KIND_LINE_LINE: begin
            ctl_in.zero    = !v2null_ff && !v1null_ff && (x1 != '0);
            ctl_in.lane_en = v2null_ff ? 4'b0100 : 4'b0001;
         end
         default: begin
            ctl_in.zero = 1'b1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else begin
         ctl_ff <= ctl_in;
      end
   end

   assign ctl = ctl_ff;

   a_segseg_all_lanes: assert property (@(posedge clock) disable iff (reset)
      ctl_ff.valid && ctl_ff.lane_en[3] |-> (ctl_ff.lane_en[2:0] == 3'b111))
      else $error("lane 3 enabled without lanes 0 to 2");

   a_valid_follows_input: assert property (@(posedge clock) disable iff (reset)
      ctl_ff.valid |-> $past(in_valid, 3))
      else $error("front valid without input three cycles earlier");

   a_zero_has_kind: assert property (@(posedge clock) disable iff (reset)
      ctl_ff.valid && !ctl_ff.zero |-> (ctl_ff.lane_en != '0))
      else $error("non-zero result with no lane enabled");

endmodule

`default_nettype wire

[src/pdu_lane.sv]
// ----------------------------------------------------------------------------
// pdu_lane : squared distance from one point to one primitive
// Gives the squared distance as num/den; five register stages.
// ----------------------------------------------------------------------------
`default_nettype none

module pdu_lane #(
   parameter int COORD_BITS = 16
) (
   input  logic                                 clock,
   input  pdu_pkg::shape_type                   shape,
   input  logic signed [COORD_BITS-1:0]         a_x,
   input  logic signed [COORD_BITS-1:0]         a_y,
   input  logic signed [COORD_BITS-1:0]         b1_x,
   input  logic signed [COORD_BITS-1:0]         b1_y,
   input  logic signed [COORD_BITS-1:0]         b2_x,
   input  logic signed [COORD_BITS-1:0]         b2_y,
   output logic [4*COORD_BITS+3:0]              num,
   output logic [2*COORD_BITS+1:0]              den
);
   import pdu_pkg::*;

   localparam int DIFW = COORD_BITS + 1;
   localparam int PRW  = 2 * DIFW;
   localparam int CRW  = PRW + 1;
   localparam int MW   = CRW - 1;
   localparam int HW   = MW / 2;
   localparam int NW   = 2 * MW;
   localparam int DW   = MW;

   // stage 1
   shape_type              shape1_ff;
   logic signed [DIFW-1:0] vx_ff, vy_ff, wax_ff, way_ff, wbx_ff, wby_ff;

   always_ff @(posedge clock) begin
      shape1_ff <= shape;
      vx_ff     <= DIFW'(b2_x) - DIFW'(b1_x);
      vy_ff     <= DIFW'(b2_y) - DIFW'(b1_y);
      wax_ff    <= DIFW'(a_x) - DIFW'(b1_x);
      way_ff    <= DIFW'(a_y) - DIFW'(b1_y);
      wbx_ff    <= DIFW'(a_x) - DIFW'(b2_x);
      wby_ff    <= DIFW'(a_y) - DIFW'(b2_y);
   end

   // stage 2
   shape_type             shape2_ff;
   logic                  vnull2_ff;
   logic signed [PRW-1:0] da_x_ff, da_y_ff, db_x_ff, db_y_ff, cr_a_ff, cr_b_ff;
   logic signed [PRW-1:0] sa_x_ff, sa_y_ff, sb_x_ff, sb_y_ff, sv_x_ff, sv_y_ff;

   always_ff @(posedge clock) begin
      shape2_ff <= shape1_ff;
      vnull2_ff <= (vx_ff == '0) && (vy_ff == '0);
      da_x_ff   <= vx_ff * wax_ff;
      da_y_ff   <= vy_ff * way_ff;
      db_x_ff   <= vx_ff * wbx_ff;
      db_y_ff   <= vy_ff * wby_ff;
      cr_a_ff   <= vx_ff * way_ff;
      cr_b_ff   <= vy_ff * wax_ff;
      sa_x_ff   <= wax_ff * wax_ff;
      sa_y_ff   <= way_ff * way_ff;
      sb_x_ff   <= wbx_ff * wbx_ff;
      sb_y_ff   <= wby_ff * wby_ff;
      sv_x_ff   <= vx_ff * vx_ff;
      sv_y_ff   <= vy_ff * vy_ff;
   end

   // stage 3: dot and cross products, region decision
   logic signed [CRW-1:0] dot_a, dot_b, crs, pp1_s, pp2_s, vv_s;
   logic [DW-1:0]         pp1, pp2;
   logic                  use_line_in;
   logic                  use_line3_ff;
   logic [MW-1:0]         cmag3_ff;
   logic [DW-1:0]         vv3_ff, ppmin3_ff, ppmin_in;

   assign dot_a = CRW'(da_x_ff) + CRW'(da_y_ff);
   assign dot_b = CRW'(db_x_ff) + CRW'(db_y_ff);
   assign crs   = CRW'(cr_a_ff) - CRW'(cr_b_ff);
   assign pp1_s = CRW'(sa_x_ff) + CRW'(sa_y_ff);
   assign pp2_s = CRW'(sb_x_ff) + CRW'(sb_y_ff);
   assign vv_s  = CRW'(sv_x_ff) + CRW'(sv_y_ff);
   assign pp1   = pp1_s[DW-1:0];
   assign pp2   = pp2_s[DW-1:0];

   always_comb begin
      use_line_in = 1'b0;
      ppmin_in    = pp1;
      unique case (shape2_ff)
         SHAPE_POINT: begin
            use_line_in = 1'b0;
         end
         SHAPE_SEG: begin
            use_line_in = (dot_a >= 0) && (dot_b <= 0);
            ppmin_in    = (pp1 <= pp2) ? pp1 : pp2;
         end
         SHAPE_RAY: begin
            use_line_in = (dot_a >= 0);
         end
         SHAPE_LINE: begin
            use_line_in = 1'b1;
         end
         default: begin
            use_line_in = 1'b0;
         end
      endcase
      if (vnull2_ff) begin
         use_line_in = 1'b0;
         ppmin_in    = pp1;
      end
   end

   always_ff @(posedge clock) begin
      use_line3_ff <= use_line_in;
      cmag3_ff     <= (crs < 0) ? MW'(-crs) : MW'(crs);
      vv3_ff       <= vv_s[DW-1:0];
      ppmin3_ff    <= ppmin_in;
   end

   // stage 4: partial products of the squared cross term
   logic [2*(MW-HW)-1:0] hh4_ff;
   logic [MW-1:0]        hl4_ff;
   logic [2*HW-1:0]      ll4_ff;
   logic                 use_line4_ff;
   logic [DW-1:0]        vv4_ff, ppmin4_ff;

   always_ff @(posedge clock) begin
      hh4_ff       <= cmag3_ff[MW-1:HW] * cmag3_ff[MW-1:HW];
      hl4_ff       <= cmag3_ff[MW-1:HW] * cmag3_ff[HW-1:0];
      ll4_ff       <= cmag3_ff[HW-1:0] * cmag3_ff[HW-1:0];
      use_line4_ff <= use_line3_ff;
      vv4_ff       <= vv3_ff;
      ppmin4_ff    <= ppmin3_ff;
   end

   // stage 5
   logic [NW-1:0] csq;
   logic [NW-1:0] num_ff;
   logic [DW-1:0] den_ff;

   assign csq = (NW'(hh4_ff) << (2 * HW)) + (NW'(hl4_ff) << (HW + 1)) + NW'(ll4_ff);

   always_ff @(posedge clock) begin
      num_ff <= use_line4_ff ? csq : NW'(ppmin4_ff);
      den_ff <= use_line4_ff ? vv4_ff : DW'(1);
   end

   assign num = num_ff;
   assign den = den_ff;

endmodule

`default_nettype wire

[src/pdu_cell.sv]
// ----------------------------------------------------------------------------
// pdu_cell : one bit of the fixed-point square root
// Tries bit BIT of res against rem = N - res^2*den, keeps dr = den*res.
// ----------------------------------------------------------------------------
`default_nettype none

module pdu_cell #(
   parameter int BIT = 0,
   parameter int TW  = 100,
   parameter int DRW = 67,
   parameter int DW  = 34
) (
   input  logic                          clock,
   input  logic [TW-1:0]                 rem_in,
   input  logic [DRW-1:0]                dr_in,
   input  logic [DW-1:0]                 den_in,
   input  logic [pdu_pkg::OUT_BITS-1:0]  res_in,
   output logic [TW-1:0]                 rem_out,
   output logic [DRW-1:0]                dr_out,
   output logic [DW-1:0]                 den_out,
   output logic [pdu_pkg::OUT_BITS-1:0]  res_out
);
   import pdu_pkg::*;

   logic [TW-1:0]       trial;
   logic                take;
   logic [TW-1:0]       rem_ff;
   logic [DRW-1:0]      dr_ff;
   logic [DW-1:0]       den_ff;
   logic [OUT_BITS-1:0] res_ff;

   // (res + 2^BIT)^2 * den - res^2 * den
   assign trial = (TW'(dr_in) << (BIT + 1)) + (TW'(den_in) << (2 * BIT));
   assign take  = (trial <= rem_in);

   always_ff @(posedge clock) begin
      rem_ff <= take ? rem_in - trial : rem_in;
      dr_ff  <= take ? dr_in + (DRW'(den_in) << BIT) : dr_in;
      den_ff <= den_in;
      res_ff <= take ? (res_in | (OUT_BITS'(1) << BIT)) : res_in;
   end

   assign rem_out = rem_ff;
   assign dr_out  = dr_ff;
   assign den_out = den_ff;
   assign res_out = res_ff;

endmodule

`default_nettype wire

[src/planar_primitive_distance_unit.sv]
// ----------------------------------------------------------------------------
// planar_primitive_distance_unit : distance between two planar primitives
// Four point-to-primitive lanes, each followed by a row of square-root cells,
// with a crossing test alongside; the result is the minimum over the lanes.
// ----------------------------------------------------------------------------
// Path: rsp_valid rises once a transaction has passed the five lane stages, one
//    square-root cell per result bit and the output flop, and the result is taken
//    at the edge that ends the cycle in which rsp_valid is high.
// Throughput: one transaction per cycle; busy is always low.
// Reset clears the valid pipeline only; transactions in flight are dropped.
// Results cannot be held off: rsp_valid is a one-cycle strobe.
`default_nettype none

module planar_primitive_distance_unit #(
   parameter int COORD_BITS = 16,
   parameter int FRAC_BITS  = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [3:0]                    req_kind,
   input  logic signed [COORD_BITS-1:0]  req_p_x,
   input  logic signed [COORD_BITS-1:0]  req_p_y,
   input  logic signed [COORD_BITS-1:0]  req_q_x,
   input  logic signed [COORD_BITS-1:0]  req_q_y,
   input  logic signed [COORD_BITS-1:0]  req_r_x,
   input  logic signed [COORD_BITS-1:0]  req_r_y,
   input  logic signed [COORD_BITS-1:0]  req_s_x,
   input  logic signed [COORD_BITS-1:0]  req_s_y,
   output logic                          rsp_valid,
   output logic [pdu_pkg::OUT_BITS-1:0]  rsp_distance
);
   import pdu_pkg::*;

   // lane widths: squared cross term over squared direction length
   localparam int NW   = 4 * COORD_BITS + 4;
   localparam int DW   = 2 * COORD_BITS + 2;
   localparam int RW   = NW + 2 * FRAC_BITS;
   localparam int DRW  = DW + OUT_BITS;
   localparam int TW   = ((RW > DRW + OUT_BITS) ? RW : DRW + OUT_BITS) + 1;
   localparam int LAT  = OUT_BITS + 6;
   localparam int NCTL = OUT_BITS + 2;

   logic accept;

   // never stalls: a new transaction may enter every cycle
   assign busy   = 1'b0;
   assign accept = start && !busy;

   // ------------------------------------------------------------------
   // crossing tests and lane enables (three stages)
   // ------------------------------------------------------------------
   pipe_ctl_type front_ctl;

   pdu_front #(
      .COORD_BITS (COORD_BITS)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .in_valid (accept),
      .kind     (req_kind),
      .p_x      (req_p_x),
      .p_y      (req_p_y),
      .q_x      (req_q_x),
      .q_y      (req_q_y),
      .r_x      (req_r_x),
      .r_y      (req_r_y),
      .s_x      (req_s_x),
      .s_y      (req_s_y),
      .ctl      (front_ctl)
   );

   // Control shift line: two slots to meet the lane outputs, then one per
   // square-root cell so that flags arrive with the lane results.
   pipe_ctl_type ctl_ff [NCTL];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < NCTL; k++) begin
            ctl_ff[k] <= '0;
         end
      end else begin
         ctl_ff[0] <= front_ctl;
         for (int k = 1; k < NCTL; k++) begin
            ctl_ff[k] <= ctl_ff[k-1];
         end
      end
   end

   // ------------------------------------------------------------------
   // lane operands
   //   lane 0: p against (r,s)   lane 1: q against (r,s)
   //   lane 2: r against (p,q)   lane 3: s against (p,q)
   // ------------------------------------------------------------------
   logic signed [COORD_BITS-1:0] ln_ax  [NUM_LANES];
   logic signed [COORD_BITS-1:0] ln_ay  [NUM_LANES];
   logic signed [COORD_BITS-1:0] ln_b1x [NUM_LANES];
   logic signed [COORD_BITS-1:0] ln_b1y [NUM_LANES];
   logic signed [COORD_BITS-1:0] ln_b2x [NUM_LANES];
   logic signed [COORD_BITS-1:0] ln_b2y [NUM_LANES];

   always_comb begin
      ln_ax[0] = req_p_x;  ln_ay[0] = req_p_y;
      ln_ax[1] = req_q_x;  ln_ay[1] = req_q_y;
      ln_ax[2] = req_r_x;  ln_ay[2] = req_r_y;
      ln_ax[3] = req_s_x;  ln_ay[3] = req_s_y;
      for (int k = 0; k < NUM_LANES; k++) begin
         if (k < 2) begin
            ln_b1x[k] = req_r_x;  ln_b1y[k] = req_r_y;
            ln_b2x[k] = req_s_x;  ln_b2y[k] = req_s_y;
         end else begin
            ln_b1x[k] = req_p_x;  ln_b1y[k] = req_p_y;
            ln_b2x[k] = req_q_x;  ln_b2y[k] = req_q_y;
         end
      end
   end

   // square-root chains: slot 0 is the lane output, slot OUT_BITS the root
   logic [TW-1:0]       rem_c [NUM_LANES][OUT_BITS+1];
   logic [DRW-1:0]      dr_c  [NUM_LANES][OUT_BITS+1];
   logic [DW-1:0]       den_c [NUM_LANES][OUT_BITS+1];
   logic [OUT_BITS-1:0] res_c [NUM_LANES][OUT_BITS+1];
   logic [NW-1:0]       lane_num [NUM_LANES];

   for (genvar i = 0; i < NUM_LANES; i++) begin : g_lane
      pdu_lane #(
         .COORD_BITS (COORD_BITS)
      ) u_lane (
         .clock (clock),
         .shape (lane_shape(req_kind, 2'(i))),
         .a_x   (ln_ax[i]),
         .a_y   (ln_ay[i]),
         .b1_x  (ln_b1x[i]),
         .b1_y  (ln_b1y[i]),
         .b2_x  (ln_b2x[i]),
         .b2_y  (ln_b2y[i]),
         .num   (lane_num[i]),
         .den   (den_c[i][0])
      );

      // target is num * 2^(2*FRAC_BITS), remainder starts there
      assign rem_c[i][0] = TW'(lane_num[i]) << (2 * FRAC_BITS);
      assign dr_c[i][0]  = '0;
      assign res_c[i][0] = '0;

      // one cell per result bit, most significant first
      for (genvar j = 0; j < OUT_BITS; j++) begin : g_cell
         pdu_cell #(
            .BIT (OUT_BITS - 1 - j),
            .TW  (TW),
            .DRW (DRW),
            .DW  (DW)
         ) u_cell (
            .clock   (clock),
            .rem_in  (rem_c[i][j]),
            .dr_in   (dr_c[i][j]),
            .den_in  (den_c[i][j]),
            .res_in  (res_c[i][j]),
            .rem_out (rem_c[i][j+1]),
            .dr_out  (dr_c[i][j+1]),
            .den_out (den_c[i][j+1]),
            .res_out (res_c[i][j+1])
         );
      end
   end

   // ------------------------------------------------------------------
   // minimum over enabled lanes; rounding down commutes with the minimum
   // ------------------------------------------------------------------
   pipe_ctl_type        ctl_end;
   logic [OUT_BITS-1:0] best;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [OUT_BITS-1:0] rsp_distance_ff, rsp_distance_in;

   assign ctl_end = ctl_ff[NCTL-1];

   always_comb begin
      best = '1;
      for (int k = 0; k < NUM_LANES; k++) begin
         if (ctl_end.lane_en[k] && (res_c[k][OUT_BITS] < best)) begin
            best = res_c[k][OUT_BITS];
         end
      end
   end

   assign rsp_valid_in    = ctl_end.valid;
   assign rsp_distance_in = ctl_end.zero ? '0 : best;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_distance_ff <= rsp_distance_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_distance = rsp_distance_ff;

   // ------------------------------------------------------------------
   // checks
   // ------------------------------------------------------------------
   a_rsp_after_latency: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(accept, LAT))
      else $error("result strobe without a transaction LAT cycles earlier");

   a_lane_for_nonzero: assert property (@(posedge clock) disable iff (reset)
      ctl_end.valid && !ctl_end.zero |-> (ctl_end.lane_en != '0))
      else $error("non-zero result with every lane disabled");

   a_zero_gives_zero: assert property (@(posedge clock) disable iff (reset)
      ctl_end.valid && ctl_end.zero |=> rsp_valid && (rsp_distance == '0))
      else $error("crossing transaction did not give distance zero");

endmodule

`default_nettype wire
